FILE: hdl/dnle_pkg.sv
// dnle_pkg: shared types and constants of the DNS name label encoder.
// Used by the result queue, the top level, the checker and the testbench.
package dnle_pkg;

  localparam int unsigned MAX_BUFFER = 512;
  localparam int unsigned MAX_LABEL  = 63;

  localparam logic [7:0]  DOT_CHAR    = 8'd46;
  localparam logic [7:0]  END_CHAR    = 8'd0;
  localparam logic [6:0]  COUNT_SAT   = 7'd64;
  localparam logic [9:0]  BUF_SIZE_RST = 10'd496;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [8:0] out_position;
    logic       name_done;
    logic       status;
    logic [9:0] encoded_length;
  } result_t;

  // Results pushed into the queue in one cycle: zero, one or two.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

FILE: hdl/dnle_ifs.sv
// Valid/ready channel interfaces of the DNS name label encoder.
// Depends on dnle_pkg for nothing but keeps field widths of the encoder.
interface dnle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;

  modport source (output valid, output name_char, input ready);
  modport sink   (input valid, input name_char, output ready);
endinterface

interface dnle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [8:0] out_position;
  logic       name_done;
  logic       status;
  logic [9:0] encoded_length;

  modport source (output valid, output out_byte, output out_position, output name_done,
                  output status, output encoded_length, input ready);
  modport sink   (input valid, input out_byte, input out_position, input name_done,
                  input status, input encoded_length, output ready);
endinterface

FILE: hdl/dnle_res_fifo.sv
// dnle_res_fifo: four-entry result queue, up to two pushes and one pop a cycle.
// Depends on dnle_pkg (result_t, push_t).
module dnle_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  dnle_pkg::push_t   push,
  output logic              room2,
  output logic              head_valid,
  output dnle_pkg::result_t head,
  input  logic              pop
);

  localparam int DEPTH = 4;

  dnle_pkg::result_t mem_r [DEPTH];
  logic [1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [2:0]        n_push;
  logic              do_pop;

  assign do_pop     = pop && (cnt_r != 3'd0);
  assign n_push     = {2'b00, push.push0} + {2'b00, push.push1};
  assign room2      = (cnt_r <= 3'(DEPTH - 2));
  assign head_valid = (cnt_r != 3'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[1:0];
    rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
    cnt_nxt    = cnt_r + n_push - {2'b00, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_r + 2'd1] <= push.res1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 3'd0) |-> (cnt_r + n_push - {2'b00, do_pop}) <= 3'(DEPTH))
    else $error("result queue overflow");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second push without first");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[1:0])
    else $error("queue pointers disagree with count");

endmodule

FILE: hdl/dns_name_label_encoder.sv
// dns_name_label_encoder: top level of the DNS host name label encoder.
// Depends on dnle_pkg, dnle_ifs (dnle_in_if, dnle_out_if) and dnle_res_fifo.
//
// Usage:
//   in_ch carries one host name character per request; character 0 ends the
//   name and '.' separates labels. out_ch carries the wire-format bytes with
//   their buffer positions: label characters as they arrive, each label's
//   length byte when its '.' or the end arrives, and a final request with
//   name_done set carrying the terminator, status and encoded length.
//   cfg_we/cfg_wdata write the buffer capacity (values above 512 act as 512);
//   write it only while no name is in flight.
// Output: a result is written into the result queue when its character is
//   taken and reaches out_ch from there. Throughput: one character per cycle
//   while the queue has room for two results; the end character of a name
//   that closes a label gives two results, which out_ch hands on in turn.
// Reset (rst_n low, synchronous): the buffer capacity returns to 496, the name
//   state goes back to a label start and the result queue empties.
// Stall: results wait in a four-entry queue; in_ch.ready stays high while the
//   queue has room for two more results and drops otherwise, so nothing is
//   lost while out_ch.ready is low.
module dns_name_label_encoder (
  input  logic              clk,
  input  logic              rst_n,
  dnle_in_if.sink           in_ch,
  dnle_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [9:0]        cfg_wdata
);

  typedef enum logic [1:0] {
    MODE_SCAN,
    MODE_LABEL,
    MODE_SKIP,
    MODE_ERROR
  } mode_t;

  logic [9:0] buf_size_r;
  logic [9:0] wp_r, wp_nxt;
  logic [8:0] lsp_r, lsp_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  mode_t      mode_r, mode_nxt;

  logic              accept;
  logic              room2;
  logic [9:0]        size_eff;
  dnle_pkg::push_t   push;
  dnle_pkg::result_t head;
  logic              head_valid;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = room2;
  // clamp the configured size to the buffer maximum
  assign size_eff = (buf_size_r > 10'(dnle_pkg::MAX_BUFFER)) ?
                    10'(dnle_pkg::MAX_BUFFER) : buf_size_r;

  // One pass over the incoming character: next name state and the results.
  always_comb begin
    logic [7:0] c;
    mode_t      m;
    logic [9:0] wp;
    logic [8:0] lsp;
    logic [6:0] cnt;
    logic       go_on;
    dnle_pkg::result_t r_len, r_end, r_chr;

    c     = in_ch.name_char;
    m     = (size_eff < 10'd2) ? MODE_ERROR : mode_r;
    wp    = wp_r;
    lsp   = lsp_r;
    cnt   = cnt_r;
    go_on = 1'b0;

    r_len = '{out_byte: {1'b0, cnt_r}, out_position: lsp_r, name_done: 1'b0,
              status: dnle_pkg::STATUS_OK, encoded_length: 10'd0};
    r_end = '{out_byte: 8'd0, out_position: wp_r[8:0], name_done: 1'b1,
              status: dnle_pkg::STATUS_OK, encoded_length: wp_r + 10'd1};
    r_chr = '{out_byte: c, out_position: wp_r[8:0], name_done: 1'b0,
              status: dnle_pkg::STATUS_OK, encoded_length: 10'd0};

    push = '{push0: 1'b0, push1: 1'b0, res0: r_end, res1: r_end};

    if (c == dnle_pkg::END_CHAR) begin
      if (m == MODE_LABEL && cnt_r > 7'(dnle_pkg::MAX_LABEL)) begin
        m = MODE_ERROR;
      end
      case (m)
        MODE_ERROR: begin
          push.push0 = 1'b1;
          push.res0  = '{out_byte: 8'd0, out_position: 9'd0, name_done: 1'b1,
                         status: dnle_pkg::STATUS_BAD, encoded_length: 10'd0};
        end
        MODE_LABEL: begin
          push.push0 = 1'b1;
          push.res0  = r_len;
          push.push1 = 1'b1;
          push.res1  = r_end;
        end
        default: begin
          push.push0 = 1'b1;
          push.res0  = r_end;
        end
      endcase
      // drop the name state
      wp  = '0;
      lsp = '0;
      cnt = '0;
      m   = MODE_SCAN;
    end else begin
      case (m)
        MODE_SCAN: begin
          if (wp_r >= size_eff - 10'd2) begin
            m = MODE_SKIP;
          end else if (c == dnle_pkg::DOT_CHAR) begin
            m = MODE_ERROR;
          end else begin
            // reserve the length slot and fall into the label path
            lsp   = wp_r[8:0];
            wp    = wp_r + 10'd1;
            cnt   = 7'd0;
            m     = MODE_LABEL;
            go_on = 1'b1;
          end
        end
        MODE_LABEL: begin
          if (c == dnle_pkg::DOT_CHAR) begin
            if (cnt_r == 7'd0 || cnt_r > 7'(dnle_pkg::MAX_LABEL)) begin
              m = MODE_ERROR;
            end else begin
              push.push0 = 1'b1;
              push.res0  = r_len;
              m          = MODE_SCAN;
            end
          end else begin
            go_on = 1'b1;
          end
        end
        default: begin
          // skipping or error: hold until the end character
        end
      endcase

      if (go_on) begin
        if (cnt < dnle_pkg::COUNT_SAT) begin
          cnt = cnt + 7'd1;
        end
        if (wp < size_eff - 10'd1) begin
          push.push0            = 1'b1;
          push.res0             = r_chr;
          push.res0.out_position = wp[8:0];
          wp                    = wp + 10'd1;
        end
      end
    end

    wp_nxt   = wp;
    lsp_nxt  = lsp;
    cnt_nxt  = cnt;
    mode_nxt = m;

    if (!accept) begin
      push.push0 = 1'b0;
      push.push1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= dnle_pkg::BUF_SIZE_RST;
      wp_r       <= '0;
      lsp_r      <= '0;
      cnt_r      <= '0;
      mode_r     <= MODE_SCAN;
    end else begin
      if (cfg_we) begin
        buf_size_r <= cfg_wdata;
      end
      if (accept) begin
        wp_r   <= wp_nxt;
        lsp_r  <= lsp_nxt;
        cnt_r  <= cnt_nxt;
        mode_r <= mode_nxt;
      end
    end
  end

  dnle_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room2      (room2),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_ch.ready)
  );

  assign out_ch.valid          = head_valid;
  assign out_ch.out_byte       = head.out_byte;
  assign out_ch.out_position   = head.out_position;
  assign out_ch.name_done      = head.name_done;
  assign out_ch.status         = head.status;
  assign out_ch.encoded_length = head.encoded_length;

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.name_char == dnle_pkg::END_CHAR) |=>
      (wp_r == 10'd0 && cnt_r == 7'd0 && mode_r == MODE_SCAN))
    else $error("name state not cleared after end character");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dnle_pkg::COUNT_SAT)
    else $error("label count beyond saturation");

  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.name_char == dnle_pkg::END_CHAR) |->
      (push.push0 && (push.push1 ? push.res1.name_done : push.res0.name_done)))
    else $error("end character without final result");

endmodule

FILE: sim/dnle_checker.sv
`timescale 1ns / 1ps
// dnle_checker: watches the name and wire-byte channels of the label encoder,
// predicts every wire byte from the accepted characters and compares them.
// Depends on dnle_pkg and the channel interfaces in dnle_ifs.
module dnle_checker (
  input  logic       clk,
  input  logic       rst_n,
  dnle_in_if         in_ch,
  dnle_out_if        out_ch,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata,
  output int         mismatches,
  output int         results_due,
  output int         results_checked
);

  typedef enum logic [1:0] {NEXT_LABEL, IN_LABEL, BUFFER_FULL, BAD_NAME} encode_mode_t;

  dnle_pkg::result_t wire_q[$];
  logic [9:0]        buf_size;
  int unsigned       wr_ptr;
  int unsigned       lbl_start;
  int unsigned       lbl_count;
  encode_mode_t      mode;

  function automatic dnle_pkg::result_t wire_result(logic [7:0] b, int unsigned pos,
                                                    logic done, logic st,
                                                    int unsigned len);
    dnle_pkg::result_t r;
    r.out_byte       = b;
    r.out_position   = 9'(pos);
    r.name_done      = done;
    r.status         = st;
    r.encoded_length = 10'(len);
    return r;
  endfunction

  task automatic restart_name();
    wr_ptr    = 0;
    lbl_start = 0;
    lbl_count = 0;
    mode      = NEXT_LABEL;
  endtask

  // Advance the encoder state by one character and queue the wire bytes it makes.
  task automatic encode_char(input logic [7:0] c);
    int unsigned lim;
    lim = (buf_size > dnle_pkg::MAX_BUFFER) ? dnle_pkg::MAX_BUFFER : buf_size;
    if (lim < 2) mode = BAD_NAME;

    if (c == dnle_pkg::END_CHAR) begin
      if (mode == IN_LABEL && lbl_count > dnle_pkg::MAX_LABEL) mode = BAD_NAME;
      if (mode == BAD_NAME) begin
        wire_q.push_back(wire_result(8'd0, 0, 1'b1, dnle_pkg::STATUS_BAD, 0));
      end else begin
        if (mode == IN_LABEL)
          wire_q.push_back(wire_result(8'(lbl_count), lbl_start, 1'b0,
                                       dnle_pkg::STATUS_OK, 0));
        wire_q.push_back(wire_result(dnle_pkg::END_CHAR, wr_ptr, 1'b1,
                                     dnle_pkg::STATUS_OK, wr_ptr + 1));
      end
      restart_name();
      return;
    end

    if (mode == BAD_NAME || mode == BUFFER_FULL) return;

    if (mode == NEXT_LABEL) begin
      if (wr_ptr >= lim - 2) begin
        mode = BUFFER_FULL;
        return;
      end
      if (c == dnle_pkg::DOT_CHAR) begin
        mode = BAD_NAME;
        return;
      end
      lbl_start = wr_ptr;
      wr_ptr++;
      lbl_count = 0;
      mode      = IN_LABEL;
    end

    if (c == dnle_pkg::DOT_CHAR) begin
      if (lbl_count == 0 || lbl_count > dnle_pkg::MAX_LABEL) begin
        mode = BAD_NAME;
      end else begin
        wire_q.push_back(wire_result(8'(lbl_count), lbl_start, 1'b0,
                                     dnle_pkg::STATUS_OK, 0));
        mode = NEXT_LABEL;
      end
      return;
    end

    if (lbl_count < dnle_pkg::COUNT_SAT) lbl_count++;
    if (wr_ptr < lim - 1) begin
      wire_q.push_back(wire_result(c, wr_ptr, 1'b0, dnle_pkg::STATUS_OK, 0));
      wr_ptr++;
    end
  endtask

  task automatic check_field(input string what, input logic [9:0] want_v,
                             input logic [9:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch on wire byte %0d: expected %0d, actual %0d",
               $time, what, results_checked, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    dnle_pkg::result_t want;
    if (!rst_n) begin
      buf_size = dnle_pkg::BUF_SIZE_RST;
      restart_name();
      wire_q.delete();
    end else begin
      if (cfg_we) buf_size = cfg_wdata;
      if (in_ch.valid && in_ch.ready) encode_char(in_ch.name_char);
      if (out_ch.valid && out_ch.ready) begin
        if (wire_q.size() == 0) begin
          $display("%0t: unexpected wire byte: expected none, actual byte %0d at %0d",
                   $time, out_ch.out_byte, out_ch.out_position);
          mismatches++;
        end else begin
          want = wire_q.pop_front();
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("out_position", want.out_position, out_ch.out_position);
          check_field("name_done", want.name_done, out_ch.name_done);
          check_field("status", want.status, out_ch.status);
          check_field("encoded_length", want.encoded_length, out_ch.encoded_length);
          results_checked++;
        end
      end
    end
    results_due = wire_q.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// testbench: drives host names into dns_name_label_encoder and gives the verdict.
// Depends on dnle_pkg, dnle_ifs, the encoder RTL and dnle_checker.
module testbench;

  typedef logic [7:0] char_q_t[$];
  typedef enum {WELL_FORMED, LONG_LABEL, BROKEN, EMPTY_NAME, NOISE, BUFFER_FILL} name_kind_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [9:0] cfg_wdata;

  int fail_count;
  int results_due;
  int results_checked;

  // Idle rates of the two sides, in percent of cycles.
  int src_idle_pct;
  int sink_idle_pct;

  int items_sent;
  int names_sent;
  int sizes_used;

  char_q_t name_buf;

  dnle_in_if  in_ch();
  dnle_out_if out_ch();

  dns_name_label_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  dnle_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (fail_count),
    .results_due    (results_due),
    .results_checked(results_checked)
  );

  always #10 clk = ~clk;

  // Receiver: drop ready at random, decided at every falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Hard stop in case a request is lost or the block hangs.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one character; hold valid and data until the request is taken.
  // Entered and left at a falling edge.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.name_char <= c;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Send the characters in name_buf, then the end character.
  task automatic send_name();
    foreach (name_buf[i]) send_char(name_buf[i]);
    send_char(dnle_pkg::END_CHAR);
    names_sent++;
  endtask

  // Hold the sender until every expected wire byte has come out, then let
  // the block finish a request that makes no output.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_buffer_size(input logic [9:0] sz);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= sz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sizes_used++;
  endtask

  // Append a label of random characters, never a dot or the end character.
  task automatic add_label(input int len);
    logic [7:0] c;
    repeat (len) begin
      do c = 8'($urandom_range(1, 255)); while (c == dnle_pkg::DOT_CHAR);
      name_buf.push_back(c);
    end
  endtask

  task automatic make_name(input name_kind_t kind);
    int n;
    int long_at;
    int extra_dot_at;
    name_buf = {};
    case (kind)
      WELL_FORMED, LONG_LABEL, BROKEN: begin
        n = $urandom_range(1, 4);
        long_at = (kind == LONG_LABEL) ? $urandom_range(0, n - 1) : -1;
        // Broken names get an extra dot: leading, doubled, or after a trailing dot.
        extra_dot_at = (kind == BROKEN) ? $urandom_range(0, n) : -1;
        if (extra_dot_at == 0) name_buf.push_back(dnle_pkg::DOT_CHAR);
        for (int i = 0; i < n; i++) begin
          add_label((i == long_at) ? $urandom_range(60, 70) : $urandom_range(1, 12));
          if (i < n - 1) name_buf.push_back(dnle_pkg::DOT_CHAR);
          if (i + 1 == extra_dot_at) begin
            name_buf.push_back(dnle_pkg::DOT_CHAR);
            if (i == n - 1) name_buf.push_back(dnle_pkg::DOT_CHAR);
          end
        end
        if (kind != BROKEN && $urandom_range(4) == 0)
          name_buf.push_back(dnle_pkg::DOT_CHAR);
      end
      NOISE: begin
        repeat ($urandom_range(1, 10))
          name_buf.push_back(($urandom_range(3) == 0) ? dnle_pkg::DOT_CHAR
                                                      : 8'($urandom_range(1, 255)));
      end
      BUFFER_FILL: begin
        // Long labels until the name overruns the largest buffer.
        while (name_buf.size() < 530) begin
          add_label($urandom_range(40, 63));
          name_buf.push_back(dnle_pkg::DOT_CHAR);
        end
      end
      default: ;
    endcase
  endtask

  function automatic name_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 65) return WELL_FORMED;
    if (r < 75) return LONG_LABEL;
    if (r < 87) return BROKEN;
    if (r < 92) return EMPTY_NAME;
    return NOISE;
  endfunction

  initial begin
    logic [9:0] seg_sizes[10];
    int         seg_end;

    // Extremes, tiny buffers and the rarely used middle sizes.
    seg_sizes = '{10'd1023, 10'd512, 10'd24, 10'd3, 10'd96,
                  10'd2, 10'd1, 10'd40, 10'd0, 10'd8};

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = dnle_pkg::BUF_SIZE_RST;
    in_ch.valid     = 1'b0;
    in_ch.name_char = dnle_pkg::END_CHAR;
    src_idle_pct    = 0;
    sink_idle_pct   = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed names at the reset buffer size.
    name_buf = {};                                          send_name();  // empty name
    name_buf = {8'h61};                                     send_name();
    name_buf = {8'h61, dnle_pkg::DOT_CHAR};                 send_name();  // trailing dot
    name_buf = {dnle_pkg::DOT_CHAR, 8'h61};                 send_name();  // leading dot
    // empty label
    name_buf = {8'h61, dnle_pkg::DOT_CHAR, dnle_pkg::DOT_CHAR, 8'h62};
    send_name();
    // char extremes
    name_buf = {8'hFF, 8'h01, dnle_pkg::DOT_CHAR, 8'h7F};
    send_name();

    // Smallest buffers: no room for a label, then room for one character.
    set_buffer_size(10'd2);
    name_buf = {8'h61};                                     send_name();
    set_buffer_size(10'd3);
    name_buf = {8'h61, 8'h62, 8'h63};                       send_name();
    // Buffers too small for anything give the error result.
    set_buffer_size(10'd1);
    name_buf = {8'h61};                                     send_name();
    set_buffer_size(10'd0);
    name_buf = {};                                          send_name();
    set_buffer_size(10'd1023);
    name_buf = {8'h41};                                     send_name();

    // Random names in three idle patterns, each over every buffer size.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 26;
          sink_idle_pct = 66;
        end
        1: begin
          src_idle_pct  = 66;
          sink_idle_pct = 26;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      foreach (seg_sizes[s]) begin
        set_buffer_size(seg_sizes[s]);
        // Buffers below two give only the error result, so keep those segments short.
        seg_end = items_sent + ((seg_sizes[s] < 2) ? 15 : 50);
        if (phase == 0 && s == 0) begin
          make_name(BUFFER_FILL);
          send_name();
        end
        while (items_sent < seg_end) begin
          make_name(pick_kind());
          send_name();
          if ($urandom_range(19) == 0) wait_drain();
        end
      end
    end

    wait_drain();
    repeat (8) @(negedge clk);

    $display("Run covered %0d characters in %0d names over %0d buffer size writes;",
             items_sent, names_sent, sizes_used);
    $display("%0d wire bytes were compared against the prediction.", results_checked);
    if (fail_count == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/dnle_pkg.sv
hdl/dnle_ifs.sv
hdl/dnle_res_fifo.sv
hdl/dns_name_label_encoder.sv
sim/dnle_checker.sv
sim/testbench.sv
